FILE: rtl/sepia_and_row_mirror_defines.svh
`ifndef SEPIA_AND_ROW_MIRROR_DEFINES_SVH
`define SEPIA_AND_ROW_MIRROR_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define SARM_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sarm check failed");

// next-cycle implication
`define SARM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sarm check failed");

`endif

FILE: rtl/sarm_pkg.sv
package sarm_pkg;

   localparam int CFG_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPIA_EN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_EN = 2'd2;

   localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pixel_type;

   // sepia matrix in thousandths, row = output channel
   typedef logic [9:0] coef_row_type [3];
   localparam coef_row_type COEF [3] = '{
      '{10'd393, 10'd769, 10'd189},
      '{10'd349, 10'd686, 10'd168},
      '{10'd272, 10'd534, 10'd131}
   };

   // sum / 1000 == ((sum >> 3) * 33555) >> 22 for sum >> 3 below 59074
   localparam logic [15:0] DIV_MUL = 16'd33555;
   localparam int DIV_SHIFT = 22;
   localparam logic [SUM_W-1:0] SAT_SUM = 19'd256000;

endpackage

FILE: rtl/sepia_and_row_mirror.sv
// Sepia tone filter with horizontal row flip, one pixel stream in, one out.
// Requests (req_*) carry a pixel (req_kind = KIND_PIXEL) or a flush step
// (KIND_FLUSH) that drains one pending mirrored pixel. Responses (rsp_*) carry
// an RGB pixel and row_end on the last pixel of each output row.
// A request yields zero or one response; requests that yield none vanish in
// the pipe. Registers are written through csr_write/csr_index/csr_wdata;
// the user writes them only while the block is idle; the block itself does not enforce this.
// Throughput: one request per cycle while req_ready is high. A response passes
// through the input register, sepia sums, reciprocal multiply, store access and
// output register. With mirroring on, a row comes out one row late, in step
// with the pixels of the next row or with flush steps.
// The row store is a 2 x MAX_WIDTH entry RAM with one write and one read per
// cycle; its contents are not cleared at reset and need no clearing pass.
// Reset clears the counters, the bank select, the pending row and the pipe.
// When rsp_ready is low, the pipe holds; empty stages still fill, so req_ready
// drops only when every stage holds an item.
module sepia_and_row_mirror
   import sarm_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic                 rsp_row_end
);

   `include "sepia_and_row_mirror_defines.svh"

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (CW > CFG_W) ? CW : CFG_W;
   localparam int DEPTH = 2 * MAX_WIDTH;
   localparam int DAW = $clog2(DEPTH);

   typedef struct packed {
      logic           wr;
      logic           res;
      logic           pass;
      logic           row_end;
      logic [DAW-1:0] wr_addr;
      logic [DAW-1:0] rd_addr;
   } ctl_type;

   // configuration
   logic [CFG_W-1:0] row_width_ff;
   logic             sepia_ff;
   logic             mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         sepia_ff     <= 1'b0;
         mirror_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_WIDTH: row_width_ff <= csr_wdata;
            CSR_SEPIA_EN:  sepia_ff     <= csr_wdata[0];
            CSR_MIRROR_EN: mirror_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipe control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5, s4_go, accept;
   ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;

   assign en5    = !v5_ff || rsp_ready;
   assign s4_go  = v4_ff && (!ctl4_ff.res || en5);
   assign en4    = !v4_ff || s4_go;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_ready = en1;
   assign accept = req_valid && en1;

   // row state
   logic [AW-1:0] wcol_ff, wcol_in;
   logic [CW-1:0] rcol_ff, rcol_in;
   logic          wbank_ff, wbank_in;
   logic          pend_ff, pend_in;

   logic [XW-1:0] rw_x;
   logic [CW-1:0] eff_w, wm1, rcol_inc;
   logic [AW-1:0] col, pos;
   logic          last, drain_ok;
   ctl_type       ctl_in;

   always_comb begin
      rw_x = XW'(row_width_ff);
      if (row_width_ff == '0) begin
         eff_w = CW'(1);
      end else if (rw_x > XW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(rw_x);
      end
      wm1      = eff_w - CW'(1);
      rcol_inc = rcol_ff + CW'(1);
      col      = (CW'(wcol_ff) < eff_w) ? wcol_ff : wm1[AW-1:0];
      last     = (CW'(col) == wm1);
      pos      = wm1[AW-1:0] - col;
      drain_ok = pend_ff && (rcol_ff < eff_w);

      wcol_in  = wcol_ff;
      rcol_in  = rcol_ff;
      wbank_in = wbank_ff;
      pend_in  = pend_ff;

      ctl_in.wr      = 1'b0;
      ctl_in.res     = 1'b0;
      ctl_in.pass    = 1'b0;
      ctl_in.row_end = 1'b0;
      ctl_in.wr_addr = wbank_ff ? DAW'(MAX_WIDTH) + DAW'(pos) : DAW'(pos);
      ctl_in.rd_addr = wbank_ff ? DAW'(rcol_ff[AW-1:0])
                                : DAW'(MAX_WIDTH) + DAW'(rcol_ff[AW-1:0]);

      if (req_kind == KIND_PIXEL && !mirror_ff) begin
         ctl_in.res     = 1'b1;
         ctl_in.pass    = 1'b1;
         ctl_in.row_end = last;
         wcol_in        = last ? '0 : col + AW'(1);
      end else begin
         // drain one pending pixel
         if (drain_ok) begin
            ctl_in.res     = 1'b1;
            ctl_in.row_end = (rcol_ff == wm1);
            rcol_in        = rcol_inc;
            if (rcol_inc >= eff_w) begin
               pend_in = 1'b0;
            end
         end else begin
            pend_in = 1'b0;
         end
         if (req_kind == KIND_PIXEL) begin
            ctl_in.wr = 1'b1;
            if (last) begin
               wcol_in  = '0;
               wbank_in = !wbank_ff;
               pend_in  = 1'b1;
               rcol_in  = '0;
            end else begin
               wcol_in = col + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcol_ff  <= '0;
         rcol_ff  <= '0;
         wbank_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (accept) begin
         wcol_ff  <= wcol_in;
         rcol_ff  <= rcol_in;
         wbank_ff <= wbank_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff && ctl4_ff.res;
      end
   end

   // datapath
   pixel_type               pix1_ff, raw2_ff, raw3_ff, px4_ff, out5_ff, px4_in, out5_in;
   logic                    sep1_ff, sep2_ff, sep3_ff, end5_ff;
   logic [SUM_W-1:0]        sum2_in [3];
   logic [SUM_W-1:0]        sum2_ff [3];
   logic [31:0]             prod3_ff [3];
   logic [2:0]              sat3_ff;
   logic [23:0]             rdata_ff;
   logic [7:0]              chan [3];
   logic [23:0]             row_store [DEPTH];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum2_in[k] = SUM_W'(pix1_ff.r) * SUM_W'(COEF[k][0])
                    + SUM_W'(pix1_ff.g) * SUM_W'(COEF[k][1])
                    + SUM_W'(pix1_ff.b) * SUM_W'(COEF[k][2]);
      end
      for (int k = 0; k < 3; k++) begin
         chan[k] = sat3_ff[k] ? 8'hFF : prod3_ff[k][DIV_SHIFT+7:DIV_SHIFT];
      end
      if (sep3_ff) begin
         px4_in = '{r: chan[0], g: chan[1], b: chan[2]};
      end else begin
         px4_in = raw3_ff;
      end
      out5_in = ctl4_ff.pass ? px4_ff : pixel_type'(rdata_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pix1_ff <= '{r: req_red_in, g: req_green_in, b: req_blue_in};
         sep1_ff <= sepia_ff;
         ctl1_ff <= ctl_in;
      end
      if (en2) begin
         sum2_ff <= sum2_in;
         raw2_ff <= pix1_ff;
         sep2_ff <= sep1_ff;
         ctl2_ff <= ctl1_ff;
      end
      if (en3) begin
         for (int k = 0; k < 3; k++) begin
            prod3_ff[k] <= 32'(sum2_ff[k][SUM_W-1:3]) * 32'(DIV_MUL);
            sat3_ff[k]  <= (sum2_ff[k] >= SAT_SUM);
         end
         raw3_ff <= raw2_ff;
         sep3_ff <= sep2_ff;
         ctl3_ff <= ctl2_ff;
      end
      if (en4) begin
         px4_ff  <= px4_in;
         ctl4_ff <= ctl3_ff;
      end
      if (en5) begin
         out5_ff <= out5_in;
         end5_ff <= ctl4_ff.row_end;
      end
   end

   // row store: written and read as an item enters the store stage
   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         if (ctl3_ff.wr) begin
            row_store[ctl3_ff.wr_addr] <= px4_in;
         end
         if (ctl3_ff.res && !ctl3_ff.pass) begin
            rdata_ff <= row_store[ctl3_ff.rd_addr];
         end
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_red_out   = out5_ff.r;
   assign rsp_green_out = out5_ff.g;
   assign rsp_blue_out  = out5_ff.b;
   assign rsp_row_end   = end5_ff;

   `SARM_ASSERT(a_no_same_entry,
      v3_ff && ctl3_ff.wr && ctl3_ff.res && !ctl3_ff.pass,
      ctl3_ff.wr_addr != ctl3_ff.rd_addr)
   `SARM_ASSERT_NEXT(a_row_done_pending,
      accept && req_kind == KIND_PIXEL && mirror_ff && last,
      pend_ff && rcol_ff == '0)
   `SARM_ASSERT_NEXT(a_store_stage_holds,
      v4_ff && ctl4_ff.res && !en5,
      v4_ff && $stable(px4_ff) && $stable(rdata_ff))
   `SARM_ASSERT(a_ready_only_when_full,
      !req_ready,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff)

endmodule

FILE: test/sepia_mirror_checker.sv
module sepia_mirror_checker
   import sarm_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_kind,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [7:0]           rsp_red_out,
   input  logic [7:0]           rsp_green_out,
   input  logic [7:0]           rsp_blue_out,
   input  logic                 rsp_row_end,
   output int                   mismatches,
   output int                   awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      pixel_type px;
      logic      row_end;
   } out_pixel_type;

   out_pixel_type    pixels_due [$];
   pixel_type        row_banks [2*MAX_WIDTH];
   int unsigned      write_col;
   int unsigned      read_col;
   logic             bank_sel;
   logic             row_waiting;
   logic [CFG_W-1:0] row_width;
   logic             sepia_on;
   logic             mirror_on;

   function automatic int unsigned active_width();
      if (row_width == 0) return 1;
      if (row_width > MAX_WIDTH) return MAX_WIDTH;
      return row_width;
   endfunction

   // thousandths, truncated, clipped at full scale
   function automatic logic [7:0] tone_channel(int unsigned sum);
      int unsigned q;
      q = sum / 1000;
      return (q > 255) ? 8'd255 : 8'(q);
   endfunction

   function automatic pixel_type sepia_of(pixel_type p);
      pixel_type t;
      t.r = tone_channel(393 * p.r + 769 * p.g + 189 * p.b);
      t.g = tone_channel(349 * p.r + 686 * p.g + 168 * p.b);
      t.b = tone_channel(272 * p.r + 534 * p.g + 131 * p.b);
      return t;
   endfunction

   function automatic void drain_pending(int unsigned w);
      int unsigned base;
      base = bank_sel ? 0 : MAX_WIDTH;
      if (!row_waiting || read_col >= w) begin
         row_waiting = 1'b0;
         return;
      end
      pixels_due.push_back('{px: row_banks[base + read_col], row_end: read_col == w - 1});
      read_col++;
      if (read_col >= w) row_waiting = 1'b0;
   endfunction

   task automatic predict_request(logic kind, pixel_type p_in);
      int unsigned w;
      int unsigned col;
      logic        last;
      pixel_type   p;
      w = active_width();
      if (kind == KIND_FLUSH) begin
         drain_pending(w);
         return;
      end
      p = sepia_on ? sepia_of(p_in) : p_in;
      col = (write_col < w) ? write_col : w - 1;
      last = (col == w - 1);
      if (!mirror_on) begin
         write_col = last ? 0 : col + 1;
         pixels_due.push_back('{px: p, row_end: last});
         return;
      end
      row_banks[(bank_sel ? MAX_WIDTH : 0) + (w - 1 - col)] = p;
      drain_pending(w);
      if (last) begin
         write_col = 0;
         bank_sel = ~bank_sel;
         row_waiting = 1'b1;
         read_col = 0;
      end else begin
         write_col = col + 1;
      end
   endtask

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      out_pixel_type seen;
      out_pixel_type want;
      if (reset) begin
         pixels_due.delete();
         write_col = 0;
         read_col = 0;
         bank_sel = 1'b0;
         row_waiting = 1'b0;
         row_width = ROW_WIDTH_RESET;
         sepia_on = 1'b0;
         mirror_on = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROW_WIDTH: row_width = csr_wdata;
               CSR_SEPIA_EN:  sepia_on = csr_wdata[0];
               CSR_MIRROR_EN: mirror_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{px: '{rsp_red_out, rsp_green_out, rsp_blue_out}, row_end: rsp_row_end};
            if (pixels_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected pixel, expected none, actual %h", $time, seen);
            end else begin
               want = pixels_due.pop_front();
               check_field("red", want.px.r, seen.px.r);
               check_field("green", want.px.g, seen.px.g);
               check_field("blue", want.px.b, seen.px.b);
               check_field("row_end", 8'(want.row_end), 8'(seen.row_end));
            end
         end
         if (req_valid && req_ready)
            predict_request(req_kind, '{req_red_in, req_green_in, req_blue_in});
      end
      awaited = pixels_due.size();
   end

endmodule

FILE: test/tb_sepia_and_row_mirror.sv
module tb_sepia_and_row_mirror;
   timeunit 1ns;
   timeprecision 1ps;
   import sarm_pkg::*;

   localparam int MAX_WIDTH = 1024;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 560;
   localparam int WIDE_PIXELS = 30;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROW_WIDTH;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_kind = KIND_PIXEL;
   logic [7:0]           req_red_in = '0;
   logic [7:0]           req_green_in = '0;
   logic [7:0]           req_blue_in = '0;
   logic                 rsp_ready = 1'b0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire  [7:0]           rsp_red_out;
   wire  [7:0]           rsp_green_out;
   wire  [7:0]           rsp_blue_out;
   wire                  rsp_row_end;

   int   mismatches;
   int   awaited;
   int   send_idle_pct = 37;
   int   recv_idle_pct = 58;
   logic ready_held = 1'b0;
   logic req_taken = 1'b0;
   int   cur_width = MAX_WIDTH;
   int   sent_count = 0;
   int   quiet_cycles = 0;

   sepia_and_row_mirror #(.MAX_WIDTH(MAX_WIDTH)) u_top (.*);

   sepia_mirror_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (.*);

   always #2ns clock = ~clock;

   always @(negedge clock)
      rsp_ready <= ready_held || ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock)
      req_taken <= req_valid && req_ready;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_sepia_and_row_mirror failed");
         $finish;
      end
   end

   function automatic int effective(int w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   function automatic logic [7:0] any_channel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_request(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      do @(negedge clock); while (!req_taken);
      sent_count++;
   endtask

   task automatic send_flush();
      send_request(KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_rows(int rows);
      repeat (rows * cur_width) begin
         if ($urandom_range(99) < 12) send_flush();
         send_request(KIND_PIXEL, any_channel(), any_channel(), any_channel());
      end
   endtask

   task automatic empty_row_store();
      repeat (cur_width) send_flush();
   endtask

   // sender holds off until every pixel is out and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      ready_held <= 1'b1;
      while (awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      ready_held <= 1'b0;
   endtask

   task automatic configure(int width, logic sepia, logic mirror);
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_ROW_WIDTH;
      csr_wdata <= width[CFG_W-1:0];
      @(negedge clock);
      csr_index <= CSR_SEPIA_EN;
      csr_wdata <= CFG_W'(sepia);
      @(negedge clock);
      csr_index <= CSR_MIRROR_EN;
      csr_wdata <= CFG_W'(mirror);
      @(negedge clock);
      csr_write <= 1'b0;
      cur_width = effective(width);
   endtask

   initial begin
      int start_count;
      int progress;
      int width_pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero width acts as one; sepia saturation at the corners
      configure(0, 1'b1, 1'b0);
      send_request(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
      send_request(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_request(KIND_PIXEL, 8'hFF, 8'h00, 8'h00);
      send_request(KIND_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_request(KIND_PIXEL, 8'h00, 8'h00, 8'hFF);
      send_flush();

      // both banks filled, then drained by flush
      configure(4, 1'b0, 1'b1);
      send_rows(2);
      repeat (4) send_flush();
      // width shrinks mid-row: next pixel lands at position 0 and closes the row
      repeat (3) send_request(KIND_PIXEL, any_channel(), any_channel(), any_channel());
      configure(2, 1'b0, 1'b1);
      send_request(KIND_PIXEL, any_channel(), any_channel(), any_channel());
      repeat (2) send_flush();
      // read column left beyond a shrunk width
      configure(4, 1'b1, 1'b1);
      send_rows(1);
      send_flush();
      configure(1, 1'b1, 1'b1);
      repeat (2) send_flush();

      start_count = sent_count;
      while (sent_count - start_count < RANDOM_ITEMS) begin
         progress = sent_count - start_count;
         if (progress < RANDOM_ITEMS / 3) begin
            send_idle_pct <= 37;
            recv_idle_pct <= 58;
         end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct <= 58;
            recv_idle_pct <= 37;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         width_pick = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 12);
         // a pending row must never be read past the width it was written at
         if (effective(width_pick) > cur_width) empty_row_store();
         configure(width_pick, 1'($urandom_range(1)), $urandom_range(3) != 0);
         send_rows($urandom_range(1, 4));
      end

      // register above the store size, pass-through
      empty_row_store();
      configure(2047, 1'($urandom_range(1)), 1'b0);
      repeat (WIDE_PIXELS)
         send_request(KIND_PIXEL, any_channel(), any_channel(), any_channel());

      settle();
      if (mismatches == 0 && awaited == 0)
         $display("tb_sepia_and_row_mirror passed");
      else
         $display("tb_sepia_and_row_mirror failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/sarm_pkg.sv
rtl/sepia_and_row_mirror.sv
test/sepia_mirror_checker.sv
test/tb_sepia_and_row_mirror.sv
